[rtl/mips_load_store_unit_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the MIPS load/store unit
// Shorthand for clocked implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MIPS_LOAD_STORE_UNIT_TOP_ASSERT_SVH
`define MIPS_LOAD_STORE_UNIT_TOP_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define MLSU_ASSERT_SAME(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("mlsu assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define MLSU_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("mlsu assertion failed");

// Next-cycle implication that also holds across reset.
`define MLSU_ASSERT_NEXT_ALWAYS(lbl, clk, a, b) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("mlsu assertion failed");

`endif

[rtl/mlsu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsu_pkg
// Shared constants and types of the load/store unit and its byte memory.
// ----------------------------------------------------------------------------
package mlsu_pkg;

  localparam int MEM_BYTES = 1024;
  localparam int ADDR_W    = $clog2(MEM_BYTES);
  localparam int NBANK     = 4;
  localparam int BANK_W    = $clog2(NBANK);
  localparam int ROWS      = MEM_BYTES / NBANK;
  localparam int ROW_W     = ADDR_W - BANK_W;

  // stream payload widths
  localparam int IN_W  = 96;
  localparam int OUT_W = 40;

  // exact effective address: 32-bit base plus 16-bit offset, signed
  localparam int EA_W = 33;

  typedef enum logic [3:0] {
    MODE_LW  = 4'd0,
    MODE_LH  = 4'd1,
    MODE_LHU = 4'd2,
    MODE_LB  = 4'd3,
    MODE_LBU = 4'd4,
    MODE_SW  = 4'd5,
    MODE_SH  = 4'd6,
    MODE_SB  = 4'd7,
    MODE_NOP = 4'd8
  } mode_t;

  typedef enum logic [1:0] {
    SZ_BYTE,
    SZ_HALF,
    SZ_WORD
  } acc_size_t;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_LOAD,
    KIND_STORE
  } op_kind_t;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_MISALIGN  = 2'd1;
  localparam logic [1:0] ERR_RANGE     = 2'd2;

  typedef struct packed {
    logic                         rd_en;
    logic [NBANK-1:0]             wr_en;
    logic [NBANK-1:0][ROW_W-1:0]  row;
    logic [NBANK-1:0][7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic                  busy;
    logic [NBANK-1:0][7:0] rdata;
  } mem_rsp_t;

endpackage

[rtl/mlsu_bank_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsu_bank_mem
// Data memory split into byte banks by address low bits; one row per bank
// read and written per cycle, read data registered. Clears itself after reset.
// ----------------------------------------------------------------------------
module mlsu_bank_mem
  import mlsu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  logic [ROW_W:0] clr_cnt_r;
  logic [ROW_W:0] clr_cnt_nxt;
  logic           busy;

  // top bit of the counter marks the clearing sweep as done
  assign busy = !clr_cnt_r[ROW_W];

  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    if (busy) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  assign rsp.busy = busy;

  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    logic [7:0] mem [ROWS];
    logic [7:0] rd_r;

    always_ff @(posedge clk) begin
      if (busy) begin
        mem[clr_cnt_r[ROW_W-1:0]] <= '0;
      end else if (req.wr_en[b]) begin
        mem[req.row[b]] <= req.wdata[b];
      end
      if (req.rd_en) begin
        rd_r <= mem[req.row[b]];
      end
    end

    assign rsp.rdata[b] = rd_r;
  end

endmodule

[rtl/mips_load_store_unit_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_load_store_unit_top
// Memory stage: checks base+offset, then loads or stores 1/2/4 bytes
// big-endian ending at end_address.
// ----------------------------------------------------------------------------
//  channel | dir | beat payload
//  in_     | in  | mode, base_value, offset, end_address, store_data
//  out_    | out | result_value, error_code
//
// One beat per cycle while out_tready is high and no clearing sweep runs;
// stages: input reg, memory read reg, output reg. Memory is 4 byte banks so
// any 4 consecutive bytes are touched together. After reset a sweep of all
// 256 rows zeroes memory, in_tready low meanwhile. Bubbles collapse: input is
// taken while a result waits on out_tready if an earlier stage is empty.
// ----------------------------------------------------------------------------
module mips_load_store_unit_top
  import mlsu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // mode[3:0], base_value[35:4], offset[51:36], end_address[61:52],
  // store_data[93:62], zero pad[95:94]
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // result_value[31:0], error_code[33:32], zero pad[39:34]
  output logic [OUT_W-1:0] out_tdata
);

  mem_req_t mreq;
  mem_rsp_t mrsp;

  logic adv1, adv2, adv3;

  // stage 1: input register
  logic        v1_r, v1_nxt;
  logic [3:0]  mode1_r;
  logic [31:0] base1_r;
  logic [15:0] off1_r;
  logic [9:0]  end1_r;
  logic [31:0] data1_r;

  // stage 2: memory read data plus control
  logic        v2_r, v2_nxt;
  op_kind_t    kind2_r;
  acc_size_t   size2_r;
  logic        sign2_r;
  logic [1:0]  err2_r;
  logic [9:0]  end2_r;

  // stage 3: output register
  logic        ov_r, ov_nxt;
  logic [31:0] res_r;
  logic [1:0]  err_r;

  // stage 1 decode
  op_kind_t         kind1;
  acc_size_t        size1;
  logic             sign1;
  logic [EA_W-1:0]  ea;
  logic [EA_W-1:0]  ea_lim;
  logic [1:0]       err1;
  logic [ADDR_W-1:0] pos_end;

  // stage 2 assembly
  logic [31:0] word2;
  logic [31:0] load_val;

  assign adv3      = !ov_r || out_tready;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign in_tready = adv1 && !mrsp.busy;

  assign v1_nxt = in_tvalid && in_tready;
  assign v2_nxt = v1_r;
  assign ov_nxt = v2_r;

  always_comb begin
    kind1 = KIND_PASS;
    size1 = SZ_WORD;
    sign1 = 1'b0;
    case (mode1_r)
      MODE_LW:  begin kind1 = KIND_LOAD;  size1 = SZ_WORD; end
      MODE_LH:  begin kind1 = KIND_LOAD;  size1 = SZ_HALF; sign1 = 1'b1; end
      MODE_LHU: begin kind1 = KIND_LOAD;  size1 = SZ_HALF; end
      MODE_LB:  begin kind1 = KIND_LOAD;  size1 = SZ_BYTE; sign1 = 1'b1; end
      MODE_LBU: begin kind1 = KIND_LOAD;  size1 = SZ_BYTE; end
      MODE_SW:  begin kind1 = KIND_STORE; size1 = SZ_WORD; end
      MODE_SH:  begin kind1 = KIND_STORE; size1 = SZ_HALF; end
      MODE_SB:  begin kind1 = KIND_STORE; size1 = SZ_BYTE; end
      default:  begin kind1 = KIND_PASS; end
    endcase
  end

  // exact effective address, then alignment and both-ends range check
  always_comb begin
    ea = {base1_r[31], base1_r} + {{(EA_W-16){off1_r[15]}}, off1_r};
    case (size1)
      SZ_WORD: ea_lim = EA_W'(MEM_BYTES - 4);
      SZ_HALF: ea_lim = EA_W'(MEM_BYTES - 2);
      default: ea_lim = EA_W'(MEM_BYTES - 1);
    endcase
    err1 = ERR_NONE;
    if (kind1 != KIND_PASS) begin
      if ((size1 == SZ_WORD && ea[1:0] != 2'b00) || (size1 == SZ_HALF && ea[0])) begin
        err1 = err1 | ERR_MISALIGN;
      end
      if (ea[EA_W-1] || ea > ea_lim) begin
        err1 = err1 | ERR_RANGE;
      end
    end
  end

  assign pos_end = end1_r[ADDR_W-1:0];

  // byte i of the access sits at end-i; bank b takes i = end[1:0]-b
  always_comb begin
    logic [BANK_W-1:0] bi;
    logic [ADDR_W-1:0] pos;
    mreq.rd_en = adv2 && v1_r;
    for (int b = 0; b < NBANK; b++) begin
      bi  = pos_end[BANK_W-1:0] - BANK_W'(b);
      pos = pos_end - ADDR_W'(bi);
      mreq.row[b]   = pos[ADDR_W-1:BANK_W];
      mreq.wdata[b] = data1_r[8*bi +: 8];
      mreq.wr_en[b] = adv2 && v1_r && kind1 == KIND_STORE && err1 == ERR_NONE &&
                      (size1 == SZ_WORD || (size1 == SZ_HALF && bi <= 2'd1) ||
                       bi == 2'd0);
    end
  end

  always_comb begin
    logic [BANK_W-1:0] bsel;
    for (int i = 0; i < NBANK; i++) begin
      bsel = end2_r[BANK_W-1:0] - BANK_W'(i);
      word2[8*i +: 8] = mrsp.rdata[bsel];
    end
    case (size2_r)
      SZ_WORD: load_val = word2;
      SZ_HALF: load_val = {{16{sign2_r & word2[15]}}, word2[15:0]};
      default: load_val = {{24{sign2_r & word2[7]}}, word2[7:0]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= v1_nxt;
      if (adv2) v2_r <= v2_nxt;
      if (adv3) ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      mode1_r <= in_tdata[3:0];
      base1_r <= in_tdata[35:4];
      off1_r  <= in_tdata[51:36];
      end1_r  <= in_tdata[61:52];
      data1_r <= in_tdata[93:62];
    end
    if (adv2) begin
      kind2_r <= kind1;
      size2_r <= size1;
      sign2_r <= sign1;
      err2_r  <= err1;
      end2_r  <= end1_r;
    end
    if (adv3) begin
      err_r <= err2_r;
      if (err2_r != ERR_NONE) begin
        res_r <= '0;
      end else if (kind2_r == KIND_LOAD) begin
        res_r <= load_val;
      end else begin
        res_r <= {22'd0, end2_r};
      end
    end
  end

  mlsu_bank_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, err_r, res_r};

endmodule

[rtl/mlsu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlsu_checker
// Port-level checks on the load/store unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "mips_load_store_unit_top_assert.svh"

module mlsu_checker
  import mlsu_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // memory sweep keeps the input closed right after reset; pipe starts empty
  `MLSU_ASSERT_NEXT_ALWAYS(a_rst_closed, clk, !rst_n, !in_tready && !out_tvalid)

  // any error forces a zero value
  `MLSU_ASSERT_SAME(a_err_zero, clk, rst_n, out_tvalid && out_tdata[33:32] != 2'd0,
    out_tdata[31:0] == 32'd0)

  `MLSU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata))

  `MLSU_ASSERT_SAME(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[OUT_W-1:34] == '0)

endmodule

bind mips_load_store_unit_top mlsu_checker u_mlsu_checker (.*);

[bench/tb_mips_load_store_unit_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mips_load_store_unit_top
// Self-checking bench for the memory stage. A mirror of the byte memory
// predicts every result beat: loads, stores, pass-through modes, alignment
// and range errors. Both stream sides idle at random. The result side is
// also held off for a long stretch while beats keep coming.
// ----------------------------------------------------------------------------
module tb_mips_load_store_unit_top;
  import mlsu_pkg::*;

  // Packed so that mode lands in the low bits of in_tdata.
  typedef struct packed {
    logic [31:0] store_data;
    logic [9:0]  end_addr;
    logic [15:0] offset;
    logic [31:0] base;
    logic [3:0]  mode;
  } lsu_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  err;
  } lsu_result_t;

  class lsu_scoreboard;
    logic [7:0]  mem_mirror [MEM_BYTES];
    lsu_result_t pending_results [$];
    int unsigned bad_beats;
    int unsigned beats_seen;

    function new();
      foreach (mem_mirror[i]) mem_mirror[i] = 8'h00;
      bad_beats  = 0;
      beats_seen = 0;
    endfunction

    static function int unsigned access_bytes(logic [3:0] m);
      case (m)
        MODE_LW, MODE_SW:          return 4;
        MODE_LH, MODE_LHU, MODE_SH: return 2;
        MODE_LB, MODE_LBU, MODE_SB: return 1;
        default:                   return 0;
      endcase
    endfunction

    // Predict one beat and update the memory mirror on a good store.
    function lsu_result_t mem_stage_result(lsu_req_t req);
      lsu_result_t      res;
      longint           ea;
      int unsigned      nb;
      logic [ADDR_W-1:0] pos;
      nb  = access_bytes(req.mode);
      res.value = 32'(req.end_addr);
      res.err   = ERR_NONE;
      if (nb == 0) return res;
      ea = longint'($signed(req.base)) + longint'($signed(req.offset));
      if (nb > 1 && (ea & longint'(nb - 1)) != 0) res.err |= ERR_MISALIGN;
      if (ea < 0 || ea + longint'(nb) - 1 >= MEM_BYTES) res.err |= ERR_RANGE;
      if (res.err != ERR_NONE) begin
        res.value = 32'h0;
        return res;
      end
      if (req.mode inside {MODE_SW, MODE_SH, MODE_SB}) begin
        for (int i = 0; i < nb; i++) begin
          pos = req.end_addr - ADDR_W'(i);
          mem_mirror[pos] = req.store_data[8*i +: 8];
        end
        return res;
      end
      res.value = 32'h0;
      for (int i = 0; i < nb; i++) begin
        pos = req.end_addr - ADDR_W'(i);
        res.value |= 32'(mem_mirror[pos]) << (8 * i);
      end
      case (req.mode)
        MODE_LH: res.value = {{16{res.value[15]}}, res.value[15:0]};
        MODE_LB: res.value = {{24{res.value[7]}}, res.value[7:0]};
        default: ;
      endcase
      return res;
    endfunction

    function void note_input(lsu_req_t req);
      pending_results.push_back(mem_stage_result(req));
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      bad_beats++;
      if (bad_beats <= 10)
        $display("[%0t] result beat %0d: %s expected %h got %h",
                 $time, beats_seen, what, want, got);
    endfunction

    function void check_result(logic [OUT_W-1:0] beat);
      lsu_result_t want;
      beats_seen++;
      if (pending_results.size() == 0) begin
        flag("unexpected beat, value", 32'h0, beat[31:0]);
        return;
      end
      want = pending_results.pop_front();
      if (beat[31:0] !== want.value) flag("result_value", want.value, beat[31:0]);
      if (beat[33:32] !== want.err) flag("error_code", 32'(want.err), 32'(beat[33:32]));
      if (beat[OUT_W-1:34] !== '0) flag("pad bits", 32'h0, 32'(beat[OUT_W-1:34]));
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  lsu_scoreboard sb = new();
  int            send_style;
  bit            hold_pending;

  mips_load_store_unit_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  initial begin
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // style 0: back to back, 1: occasional gaps, 2: a random gap drawn for every beat
  function automatic int gap_draw(int style);
    case (style)
      0:       return 0;
      1:       return ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 18)) : 0;
      default: return int'($urandom_range(0, 18));
    endcase
  endfunction

  function automatic lsu_req_t build_req(logic [3:0] m, logic [31:0] base,
                                         logic [15:0] off, logic [9:0] end_a,
                                         logic [31:0] data);
    lsu_req_t req;
    req.mode       = m;
    req.base       = base;
    req.offset     = off;
    req.end_addr   = end_a;
    req.store_data = data;
    return req;
  endfunction

  task automatic send_item(input lsu_req_t req);
    int gap;
    gap = gap_draw(send_style);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {2'b00, req};
    in_tvalid <= 1'b1;
    @(posedge clk iff in_tready);
    sb.note_input(req);
  endtask

  // Random offset, base chosen so that base + offset hits the given address.
  task automatic send_op(input logic [3:0] m, input longint ea,
                         input logic [9:0] end_a, input logic [31:0] data);
    logic [15:0] off;
    off = 16'($urandom);
    send_item(build_req(m, 32'(ea - longint'($signed(off))), off, end_a, data));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // result side
  initial begin : result_sink
    int          stall;
    int          style;
    int unsigned taken;
    out_tready <= 1'b0;
    style = 0;
    taken = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (taken % 97 == 0) style = $urandom_range(0, 2);
      if (hold_pending) begin
        stall        = 120;
        hold_pending = 1'b0;
      end else begin
        stall = gap_draw(style);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk iff out_tvalid);
      taken++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  initial begin : stimulus
    logic [3:0]  m;
    int unsigned nb;
    int unsigned pick;
    longint      ea;
    logic [9:0]  end_a;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    send_style   = 0;
    hold_pending = 1'b0;
    @(posedge clk iff rst_n);

    // byte order and extension
    send_op(MODE_SW,  0, 10'd3, 32'h80FF_7F01);
    send_op(MODE_LW,  0, 10'd3, 32'h0);
    send_op(MODE_LH,  0, 10'd3, 32'h0);
    send_op(MODE_LH,  2, 10'd1, 32'h0);
    send_op(MODE_LHU, 2, 10'd1, 32'h0);
    send_op(MODE_LB,  3, 10'd0, 32'h0);
    send_op(MODE_LBU, 1, 10'd0, 32'h0);
    // byte positions wrap below address zero
    send_op(MODE_SW,  1020, 10'd1, 32'hA5C3_3CC5);
    send_op(MODE_LW,  4, 10'd1, 32'h0);
    send_op(MODE_LHU, 0, 10'd1023, 32'h0);
    send_op(MODE_SH,  1022, 10'd1023, 32'hFFFF_FFFF);
    send_op(MODE_SB,  1023, 10'd512, 32'h1234_56FE);
    send_op(MODE_LBU, 1023, 10'd512, 32'h0);
    send_op(MODE_SB,  0, 10'd0, 32'h0);
    // pass-through, unused modes included
    send_item(build_req(MODE_NOP, 32'h0, 16'h0, 10'd777, 32'h0));
    send_item(build_req(4'd9, 32'hFFFF_FFFF, 16'hFFFF, 10'd1023, 32'hFFFF_FFFF));
    send_item(build_req(4'd15, 32'hFFFF_FFFF, 16'hFFFF, 10'd0, 32'hFFFF_FFFF));
    // misaligned and out of range
    send_op(MODE_LW,  2, 10'd5, 32'h0);
    send_op(MODE_LH,  1, 10'd5, 32'h0);
    send_op(MODE_SW,  1023, 10'd5, 32'hDEAD_BEEF);
    send_op(MODE_LB,  -1, 10'd5, 32'h0);
    send_op(MODE_LBU, 1024, 10'd5, 32'h0);
    send_op(MODE_LW,  1024, 10'd5, 32'h0);
    send_op(MODE_LH,  1022, 10'd1023, 32'h0);
    send_op(MODE_SH,  1023, 10'd5, 32'h0);
    send_item(build_req(MODE_LW, 32'h7FFF_FFFF, 16'h7FFF, 10'd5, 32'h0));
    send_item(build_req(MODE_SB, 32'h8000_0000, 16'h8000, 10'd5, 32'hFFFF_FFFF));
    wait_drained();

    for (int n = 0; n < 1850; n++) begin
      if (n % 120 == 0) send_style = $urandom_range(0, 2);
      // fill the pipe while the result side is held off
      if (n == 600) begin
        hold_pending = 1'b1;
        send_style   = 0;
      end
      if (n == 1300) wait_drained();
      case ($urandom_range(0, 2))
        0:       end_a = 10'($urandom_range(0, 15));
        1:       end_a = 10'(MEM_BYTES - 8 + $urandom_range(0, 15));
        default: end_a = 10'($urandom);
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        m  = 4'($urandom_range(0, 7));
        nb = lsu_scoreboard::access_bytes(m);
        pick = $urandom_range(0, 99);
        if (pick < 88)
          ea = longint'($urandom_range(0, (MEM_BYTES - nb) / nb)) * nb;
        else if (pick < 94)
          ea = longint'($urandom_range(0, MEM_BYTES - 1));
        else if ($urandom_range(0, 1) == 0)
          ea = -longint'($urandom_range(1, 8));
        else
          ea = longint'(MEM_BYTES - nb + $urandom_range(1, 8));
        send_op(m, ea, end_a, $urandom);
      end else if (pick < 95) begin
        send_item(build_req(4'($urandom_range(8, 15)), $urandom, 16'($urandom),
                            end_a, $urandom));
      end else begin
        send_item(build_req(4'($urandom), $urandom, 16'($urandom),
                            10'($urandom), $urandom));
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (sb.bad_beats == 0 && sb.outstanding() == 0) begin
      $display("mips_load_store_unit_top verification clean");
    end else begin
      $display("mips_load_store_unit_top verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("mips_load_store_unit_top verification failed");
    $finish;
  end

endmodule
